// File: src/srrt_pkg.sv
`default_nettype none

package srrt_pkg;

    localparam int MAX_PACKETS   = 1024;
    localparam int SEQ_WRAP      = 32;
    localparam int CONTENT_BYTES = 1024;
    localparam int CHECK_WINDOW  = 100;

    localparam int BLOCK_BYTES  = 1024;
    localparam int BACK_JUMP    = 20;
    localparam int LATE_LIMIT   = 16;
    localparam int SETTLE_LIMIT = 12;

    localparam int SEQ_W    = 32;
    localparam int BYTES_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int ACK_W    = 32;
    localparam int BLOCK_SH = $clog2(BLOCK_BYTES);
    localparam int BLOCK_W  = SEQ_W - BLOCK_SH;
    localparam int WRAP_W   = 10;
    localparam int ADJ_W    = 5;
    localparam int IDX_W    = $clog2((2**BLOCK_W - 1) + (2**WRAP_W - 1) * SEQ_WRAP + 1);
    localparam int TOTAL_W  = $clog2(MAX_PACKETS + 1);
    localparam int MAP_AW   = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int WCNT_W   = $clog2(CHECK_WINDOW + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [MAP_AW-1:0]  map_addr;
        logic [INDEX_W-1:0] packet_index;
        logic [ACK_W-1:0]   ack_value;
        logic               index_bad;
        logic               in_window;
        logic [WCNT_W-1:0]  window_size;
    } t_entry;

    typedef struct packed {
        logic clear_done;
    } t_back_status;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOKUP
    } t_back_state;

endpackage

`default_nettype wire

// File: src/srrt_in_if.sv
`default_nettype none

interface srrt_in_if;
    import srrt_pkg::*;

    logic               valid;
    logic               ready;
    logic [SEQ_W-1:0]   raw_sequence;
    logic [BYTES_W-1:0] file_bytes;

    modport source (output valid, output raw_sequence, output file_bytes, input ready);
    modport sink   (input valid, input raw_sequence, input file_bytes, output ready);
endinterface

`default_nettype wire

// File: src/srrt_out_if.sv
`default_nettype none

interface srrt_out_if;
    import srrt_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] packet_index;
    logic [ACK_W-1:0]   ack_value;
    logic               index_bad;
    logic               all_received;

    modport source (output valid, output packet_index, output ack_value, output index_bad,
                    output all_received, input ready);
    modport sink   (input valid, input packet_index, input ack_value, input index_bad,
                    input all_received, output ready);
endinterface

`default_nettype wire

// File: src/srrt_front.sv
`default_nettype none

module srrt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    srrt_in_if.sink               i_in,
    input  srrt_pkg::t_back_status i_status,
    input  logic                  i_q_ready,
    output logic                  o_q_push,
    output srrt_pkg::t_entry      o_q_entry
);
    import srrt_pkg::*;

    logic                r_seen;
    logic [BLOCK_W-1:0]  r_prev;
    logic [WRAP_W-1:0]   r_wrap;
    logic                r_pend;
    logic [ADJ_W-1:0]    r_adj;
    logic [TOTAL_W-1:0]  r_total;

    logic [WRAP_W-1:0]   n_wrap;
    logic                n_pend;
    logic [ADJ_W-1:0]    n_adj;

    logic                w_accept;
    logic [BLOCK_W-1:0]  w_block;
    logic signed [BLOCK_W:0] w_back;
    logic [WRAP_W-1:0]   w_lap;
    logic [IDX_W-1:0]    w_idx;
    logic [BYTES_W-1:0]  w_quot;
    logic                w_rem_nz;
    logic [BYTES_W:0]    w_ceil;
    logic [TOTAL_W-1:0]  w_sat;
    logic                w_first;
    logic [TOTAL_W-1:0]  w_total;
    logic [TOTAL_W-1:0]  w_low;

    assign i_in.ready = i_status.clear_done & i_q_ready;
    assign w_accept   = i_in.valid & i_in.ready;
    assign o_q_push   = w_accept;

    assign w_block = BLOCK_W'(i_in.raw_sequence >> BLOCK_SH);
    assign w_back  = $signed({1'b0, r_prev}) - $signed({1'b0, w_block});

    always_comb begin
        n_wrap = r_wrap;
        n_pend = r_pend;
        n_adj  = r_adj;
        w_lap  = r_wrap;
        if ((w_back > $signed((BLOCK_W + 1)'(BACK_JUMP))) && !r_pend) begin
            n_wrap = r_wrap + 1'b1;
            n_adj  = '0;
            n_pend = 1'b1;
            w_lap  = r_wrap + 1'b1;
        end else if ((w_block > BLOCK_W'(BACK_JUMP)) && r_pend
                     && (r_adj < ADJ_W'(LATE_LIMIT))) begin
            w_lap = r_wrap - 1'b1;
        end else begin
            if (r_pend) begin
                n_adj = r_adj + 1'b1;
            end
            if (n_adj > ADJ_W'(SETTLE_LIMIT)) begin
                n_pend = 1'b0;
                n_adj  = '0;
            end
        end
    end

    assign w_idx = IDX_W'(w_block) + IDX_W'(32'(w_lap) * SEQ_WRAP);

    assign w_quot   = i_in.file_bytes / CONTENT_BYTES;
    assign w_rem_nz = (i_in.file_bytes % CONTENT_BYTES) != '0;
    assign w_ceil   = {1'b0, w_quot} + (BYTES_W + 1)'(w_rem_nz);
    assign w_sat    = (w_ceil > (BYTES_W + 1)'(MAX_PACKETS)) ? TOTAL_W'(MAX_PACKETS)
                                                             : TOTAL_W'(w_ceil);
    assign w_first  = !r_seen;
    assign w_total  = w_first ? w_sat : r_total;
    assign w_low    = (32'(w_total) < 32'(CHECK_WINDOW)) ? '0
                    : TOTAL_W'(32'(w_total) - 32'(CHECK_WINDOW));

    always_comb begin
        o_q_entry.map_addr     = w_idx[MAP_AW-1:0];
        o_q_entry.packet_index = w_idx[INDEX_W-1:0];
        o_q_entry.ack_value    = w_first ? ACK_W'(w_idx) : i_in.raw_sequence;
        o_q_entry.index_bad    = 32'(w_idx) >= 32'(w_total);
        o_q_entry.in_window    = 32'(w_idx) >= 32'(w_low);
        o_q_entry.window_size  = WCNT_W'(w_total - w_low);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_prev  <= '0;
            r_wrap  <= '0;
            r_pend  <= 1'b0;
            r_adj   <= '0;
            r_total <= '0;
        end else if (w_accept) begin
            r_seen  <= 1'b1;
            r_prev  <= w_block;
            r_wrap  <= n_wrap;
            r_pend  <= n_pend;
            r_adj   <= n_adj;
            r_total <= w_total;
        end
    end

endmodule

`default_nettype wire

// File: src/srrt_queue.sv
`default_nettype none

module srrt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srrt_pkg::t_entry i_entry,
    output logic             o_ready,
    output logic             o_valid,
    output srrt_pkg::t_entry o_entry,
    input  logic             i_pop
);
    import srrt_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/srrt_back.sv
`default_nettype none

module srrt_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  srrt_pkg::t_entry       i_q_entry,
    output logic                   o_pop,
    srrt_out_if.source             o_out,
    output srrt_pkg::t_back_status o_status
);
    import srrt_pkg::*;

    logic               r_map [MAX_PACKETS];
    logic               r_rd_data;
    t_back_state        r_state;
    t_back_state        n_state;
    logic [MAP_AW-1:0]  r_clr_addr;
    logic [WCNT_W-1:0]  r_marked;
    logic [WCNT_W-1:0]  n_marked;
    t_entry             r_cur;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic [ACK_W-1:0]   r_out_ack;
    logic               r_out_bad;
    logic               r_out_done;

    logic               w_clearing;
    logic               w_finish;
    logic               w_mark;
    logic               w_slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == MAP_AW'(MAX_PACKETS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (o_pop) begin
                    n_state = BK_LOOKUP;
                end
            end
            BK_LOOKUP: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    always_comb begin
        w_slot_free         = !r_out_valid || o_out.ready;
        w_clearing          = r_state == BK_CLEAR;
        w_finish            = r_state == BK_LOOKUP;
        o_pop               = (r_state == BK_IDLE) && i_q_valid && w_slot_free;
        w_mark              = w_finish && !r_cur.index_bad && !r_rd_data;
        n_marked            = r_marked + WCNT_W'(w_mark && r_cur.in_window);
        o_status.clear_done = !w_clearing;
    end

    // map: clear sweep, then one read-modify-write per beat
    always_ff @(posedge i_clk) begin
        if (w_clearing) begin
            r_map[r_clr_addr] <= 1'b0;
        end else if (w_mark) begin
            r_map[r_cur.map_addr] <= 1'b1;
        end
        if (o_pop) begin
            r_rd_data <= r_map[i_q_entry.map_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_entry;
        end
        if (w_finish) begin
            r_out_index <= r_cur.packet_index;
            r_out_ack   <= r_cur.ack_value;
            r_out_bad   <= r_cur.index_bad;
            r_out_done  <= n_marked >= r_cur.window_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_marked    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_marked <= n_marked;
            if (w_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.packet_index = r_out_index;
    assign o_out.ack_value    = r_out_ack;
    assign o_out.index_bad    = r_out_bad;
    assign o_out.all_received = r_out_done;

endmodule

`default_nettype wire

// File: src/selective_repeat_receive_tracker.sv
`default_nettype none

// Selective-repeat receive tracker. After reset all 1024 entries of the received
// map are swept clear, one entry per cycle, with input ready held low. The front
// then takes a packet header beat, unwraps its block number and classifies it
// into a two-entry queue; the back does the map read-modify-write on the single
// memory port, reading when it pops an entry and writing in the lookup state,
// and pops no new packet until that one is finished, so the back holds one
// packet at a time. The result sits in an output register, so the front takes
// up to two more beats into the queue while a result waits to be taken.
module selective_repeat_receive_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srrt_in_if.sink     i_in,
    srrt_out_if.source  o_out
);
    import srrt_pkg::*;

    t_back_status w_status;
    logic         w_push;
    t_entry       w_push_entry;
    logic         w_q_ready;
    logic         w_q_valid;
    t_entry       w_q_entry;
    logic         w_pop;

    srrt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_status  (w_status),
        .i_q_ready (w_q_ready),
        .o_q_push  (w_push),
        .o_q_entry (w_push_entry)
    );

    srrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    srrt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_q_entry),
        .o_pop     (w_pop),
        .o_out     (o_out),
        .o_status  (w_status)
    );

endmodule

`default_nettype wire

// File: src/srrt_checker.sv
`default_nettype none

module srrt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [srrt_pkg::INDEX_W-1:0] i_out_index,
    input  logic [srrt_pkg::ACK_W-1:0]   i_out_ack,
    input  logic                        i_out_bad,
    input  logic                        i_out_done
);
    logic r_done_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_done) begin
            r_done_seen <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_index)
            && $stable(i_out_ack) && $stable(i_out_bad) && $stable(i_out_done)))
        else $error("result beat changed while stalled");

    a_clear_blocks_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during map clear");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_done_seen) |-> i_out_done)
        else $error("all_received dropped after completion");

    // after each accepted input beat the completion flag must not clear without reset
    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$fell(r_done_seen))
        else $error("completion cleared without reset");

endmodule

bind selective_repeat_receive_tracker srrt_checker u_srrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.packet_index),
    .i_out_ack   (o_out.ack_value),
    .i_out_bad   (o_out.index_bad),
    .i_out_done  (o_out.all_received)
);

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
    import srrt_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int TAIL_CYCLES  = 20;
    localparam int QUIET_FROM   = 2000;
    localparam int QUIET_TO     = 3000;
    localparam int STALL_PCT    = 14;
    localparam int WRAP_ROUNDS  = 10;

    typedef struct packed {
        logic [INDEX_W-1:0] packet_index;
        logic [ACK_W-1:0]   ack_value;
        logic               index_bad;
        logic               all_received;
    } t_ack;

    typedef struct packed {
        logic [SEQ_W-1:0]   raw_sequence;
        logic [BYTES_W-1:0] file_bytes;
        logic               typed;
        t_ack               want;
    } t_row;

    localparam int N_ROWS = 20;

    // first packet saturates the total; later rows walk one wrap, a late packet,
    // a duplicate, the settle count, an out-of-range block and a second wrap
    localparam t_row DIRECTED [N_ROWS] = '{
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{10'h3FF, 32'h003F_FFFF, 1'b1, 1'b0}},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{32'(31 * BLOCK_BYTES + 1023), 32'h0000_0400, 1'b0, '0},
        '{32'(1 * BLOCK_BYTES), 32'h8000_0000, 1'b0, '0},
        '{32'(1 * BLOCK_BYTES + 5), 32'h7FFF_FFFF, 1'b0, '0},
        '{32'(2 * BLOCK_BYTES + 17), 32'h0000_0001, 1'b0, '0},
        '{32'(3 * BLOCK_BYTES + 512), 32'h5555_5555, 1'b0, '0},
        '{32'(4 * BLOCK_BYTES + 1), 32'hAAAA_AAAA, 1'b0, '0},
        '{32'(5 * BLOCK_BYTES + 2), 32'h0000_03FF, 1'b0, '0},
        '{32'(6 * BLOCK_BYTES + 4), 32'h0001_0000, 1'b0, '0},
        '{32'(7 * BLOCK_BYTES + 8), 32'h0F0F_0F0F, 1'b0, '0},
        '{32'(8 * BLOCK_BYTES + 16), 32'hF0F0_F0F0, 1'b0, '0},
        '{32'(9 * BLOCK_BYTES + 32), 32'h1234_5678, 1'b0, '0},
        '{32'(10 * BLOCK_BYTES + 64), 32'h8765_4321, 1'b0, '0},
        '{32'(11 * BLOCK_BYTES + 128), 32'hDEAD_BEEF, 1'b0, '0},
        '{32'(12 * BLOCK_BYTES + 256), 32'h0000_0000, 1'b0, '0},
        '{32'(25 * BLOCK_BYTES + 100), 32'hFFFF_0000, 1'b0, '0},
        '{32'h8000_0000, 32'h0000_0001, 1'b1, '{10'd32, 32'h8000_0000, 1'b1, 1'b0}},
        '{32'h0000_0200, 32'h0000_0000, 1'b0, '0},
        '{32'(31 * BLOCK_BYTES + 1), 32'hFFFF_FFFF, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   failures = 0;
    wire  quiet = (cycles >= QUIET_FROM) && (cycles < QUIET_TO);

    srrt_in_if  pkt_if ();
    srrt_out_if ack_if ();

    selective_repeat_receive_tracker DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (pkt_if),
        .o_out   (ack_if)
    );

    // predicted tracker state
    bit                 seen_first_q;
    logic [BLOCK_W-1:0] last_block = '0;
    logic [WRAP_W-1:0]  lap_count = '0;
    bit                 settle_pending;
    logic [ADJ_W-1:0]   settle_count = '0;
    int unsigned        total_pkts;
    bit                 got_map [MAX_PACKETS];
    int unsigned        marked_in_window;
    bit                 done_seen;

    t_ack pending_acks[$];
    bit   row_typed;
    t_ack row_want;

    function automatic t_ack track_packet(input logic [SEQ_W-1:0] raw,
                                          input logic [BYTES_W-1:0] size);
        t_ack               res;
        logic [BLOCK_W-1:0] blk;
        int                 back;
        logic [WRAP_W-1:0]  lap;
        longint unsigned    idx;
        longint unsigned    need;
        int unsigned        floor_idx;
        bit                 opening;
        blk  = raw[SEQ_W-1:BLOCK_SH];
        back = int'(last_block) - int'(blk);
        if (back > BACK_JUMP && !settle_pending) begin
            lap_count      = lap_count + 1'b1;
            settle_count   = '0;
            settle_pending = 1'b1;
            lap            = lap_count;
        end else if (blk > BACK_JUMP && settle_pending && settle_count < LATE_LIMIT) begin
            lap = lap_count - 1'b1;
        end else begin
            lap = lap_count;
            if (settle_pending)
                settle_count = settle_count + 1'b1;
            if (settle_count > SETTLE_LIMIT) begin
                settle_pending = 1'b0;
                settle_count   = '0;
            end
        end
        last_block = blk;
        idx = longint'(blk) + longint'(lap) * SEQ_WRAP;

        opening = !seen_first_q;
        if (opening) begin
            need = (longint'(size) + CONTENT_BYTES - 1) / CONTENT_BYTES;
            if (need > MAX_PACKETS)
                need = MAX_PACKETS;
            total_pkts   = int'(need);
            seen_first_q = 1'b1;
        end
        floor_idx = (total_pkts < CHECK_WINDOW) ? 0 : total_pkts - CHECK_WINDOW;

        res.index_bad = (idx >= total_pkts);
        if (!res.index_bad && !got_map[idx]) begin
            got_map[idx] = 1'b1;
            if (idx >= floor_idx)
                marked_in_window++;
        end
        res.all_received = (marked_in_window >= total_pkts - floor_idx);
        res.packet_index = idx[INDEX_W-1:0];
        res.ack_value    = opening ? idx[ACK_W-1:0] : raw;
        return res;
    endfunction

    task automatic send_packet(input logic [SEQ_W-1:0] raw, input logic [BYTES_W-1:0] size,
                               input bit typed, input t_ack want);
        while (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
            pkt_if.valid <= 1'b0;
            @(negedge clk);
        end
        pkt_if.valid        <= 1'b1;
        pkt_if.raw_sequence <= raw;
        pkt_if.file_bytes   <= size;
        row_typed           <= typed;
        row_want            <= want;
        do @(posedge clk); while (!pkt_if.ready);
        @(negedge clk);
    endtask

    task automatic send_block(input logic [BLOCK_W-1:0] blk);
        send_packet({blk, BLOCK_SH'($urandom)}, $urandom, 1'b0, '0);
    endtask

    task automatic wait_drained();
        pkt_if.valid <= 1'b0;
        do @(negedge clk); while (pending_acks.size() != 0);
    endtask

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        ack_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            ack_if.ready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

    always @(posedge clk) begin
        t_ack pred;
        t_ack got;
        t_ack want;
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end else if (rst_n) begin
            if (pkt_if.valid && pkt_if.ready) begin
                pred      = track_packet(pkt_if.raw_sequence, pkt_if.file_bytes);
                done_seen = pred.all_received;
                pending_acks.push_back(row_typed ? row_want : pred);
            end
            if (ack_if.valid && ack_if.ready) begin
                got = '{ack_if.packet_index, ack_if.ack_value, ack_if.index_bad,
                        ack_if.all_received};
                if (pending_acks.size() == 0) begin
                    $error("unexpected result beat: packet_index %0d ack_value %0h",
                           got.packet_index, got.ack_value);
                    failures++;
                end else begin
                    want = pending_acks.pop_front();
                    if (got.packet_index !== want.packet_index) begin
                        $error("packet_index: expected %0d, got %0d",
                               want.packet_index, got.packet_index);
                        failures++;
                    end
                    if (got.ack_value !== want.ack_value) begin
                        $error("ack_value: expected %0h, got %0h",
                               want.ack_value, got.ack_value);
                        failures++;
                    end
                    if (got.index_bad !== want.index_bad) begin
                        $error("index_bad: expected %0b, got %0b",
                               want.index_bad, got.index_bad);
                        failures++;
                    end
                    if (got.all_received !== want.all_received) begin
                        $error("all_received: expected %0b, got %0b",
                               want.all_received, got.all_received);
                        failures++;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned pos;
        int          n;
        int          r;
        rst_n               = 1'b0;
        pkt_if.valid        = 1'b0;
        pkt_if.raw_sequence = '0;
        pkt_if.file_bytes   = '0;
        row_typed           = 1'b0;
        row_want            = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_packet(DIRECTED[i].raw_sequence, DIRECTED[i].file_bytes,
                        DIRECTED[i].typed, DIRECTED[i].want);
        wait_drained();

        // in-order laps with local reordering and repeats until the window completes
        pos = 1;
        n   = 0;
        while (!done_seen && n < 1500) begin
            if ($urandom_range(0, 99) < 15) begin
                send_block(BLOCK_W'((pos + $urandom_range(0, 4) + SEQ_WRAP - 2) % SEQ_WRAP));
            end else begin
                send_block(BLOCK_W'(pos));
                pos = (pos + 1) % SEQ_WRAP;
            end
            n++;
        end

        // after completion: noise and broken sequences mixed in
        repeat (300) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                send_packet($urandom, $urandom, 1'b0, '0);
            end else if (r < 50) begin
                send_block(BLOCK_W'($urandom_range(0, SEQ_WRAP - 1)));
            end else begin
                send_block(BLOCK_W'(pos));
                pos = (pos + 1) % SEQ_WRAP;
            end
        end
        wait_drained();

        // force one wrap per round
        repeat (WRAP_ROUNDS) begin
            send_block(BLOCK_W'($urandom_range(2 * BACK_JUMP + 1, 2**BLOCK_W - 1)));
            send_block(BLOCK_W'($urandom_range(0, BACK_JUMP)));
            send_block(BLOCK_W'($urandom_range(BACK_JUMP + 1, 63)));
            repeat (SETTLE_LIMIT + 1) send_block(BLOCK_W'($urandom_range(0, BACK_JUMP)));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/srrt_pkg.sv
src/srrt_in_if.sv
src/srrt_out_if.sv
src/srrt_front.sv
src/srrt_queue.sv
src/srrt_back.sv
src/selective_repeat_receive_tracker.sv
src/srrt_checker.sv
test/tb.sv
